// ===== rtl/checkweigh_limit_classifier_assert.svh =====
// Assertion macros of the checkweigh limit classifier checker.
`ifndef CHECKWEIGH_LIMIT_CLASSIFIER_ASSERT_SVH
`define CHECKWEIGH_LIMIT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CWLC_ASSERT_IMPL(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("checkweigh_limit_classifier: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CWLC_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("checkweigh_limit_classifier: next-cycle check failed");

`endif

// ===== rtl/cwlc_pkg.sv =====
// Shared types and constants of the checkweigh limit classifier.
`timescale 1ns / 1ps

package cwlc_pkg;

   // Default mass width and depth of the queue between front and back
   localparam int MASS_WIDTH_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_LIMIT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_LIMIT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_GROSS    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_ENABLE = 3'd4;

   // Result state codes
   localparam int STATE_W = 3;
   typedef enum logic [STATE_W-1:0] {
      ST_DISABLED = 3'd0,
      ST_LOW      = 3'd1,
      ST_OK       = 3'd2,
      ST_HIGH     = 3'd3,
      ST_OVERLOAD = 3'd4,
      ST_FAULT    = 3'd5
   } state_type;

   // Flag part of one result word; the mass travels beside it
   typedef struct packed {
      state_type state_code;
      logic      changed;
      logic      qualified;
      logic      ok_entry;
   } rsp_flags_type;

   localparam int FLAGS_W = $bits(rsp_flags_type);

endpackage

// ===== rtl/cwlc_front.sv =====
// Front end: configuration registers, limit classification and class state.
`timescale 1ns / 1ps

module cwlc_front #(
   parameter int MASS_WIDTH = cwlc_pkg::MASS_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [cwlc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [MASS_WIDTH-1:0]              csr_data,
   input  logic                               item_accept,
   input  logic signed [MASS_WIDTH-1:0]       gross_mass,
   input  logic signed [MASS_WIDTH-1:0]       net_mass,
   input  logic                               stable_flag,
   input  logic                               overload_flag,
   input  logic                               sample_invalid,
   input  logic                               calibrating,
   output cwlc_pkg::rsp_flags_type            word_flags,
   output logic signed [MASS_WIDTH-1:0]       word_mass
);
   import cwlc_pkg::*;

   // Configuration registers
   logic signed [MASS_WIDTH-1:0] lower_ff, lower_in;
   logic signed [MASS_WIDTH-1:0] upper_ff, upper_in;
   logic [MASS_WIDTH-2:0]        hyst_ff, hyst_in;
   logic                         use_gross_ff, use_gross_in;
   logic                         enable_ff, enable_in;

   // Class state
   state_type stable_class_ff, stable_class_in;
   logic      class_valid_ff, class_valid_in;
   state_type out_state_ff, out_state_in;

   // One bit wider operands so sums and differences cannot overflow
   logic signed [MASS_WIDTH:0] lower_x, upper_x, hyst_x, mass_x;
   logic signed [MASS_WIDTH:0] lower_plus_h, upper_minus_h, span;

   logic      cfg_ok, off, fault, cls_valid;
   state_type cls_result, state_pick;
   logic      qualified, ok_entry;

   // Decode configuration writes
   always_comb begin
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      hyst_in      = hyst_ff;
      use_gross_in = use_gross_ff;
      enable_in    = enable_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LOWER_LIMIT:  lower_in     = csr_data;
            CSR_UPPER_LIMIT:  upper_in     = csr_data;
            CSR_HYSTERESIS:   hyst_in      = csr_data[MASS_WIDTH-2:0];
            CSR_USE_GROSS:    use_gross_in = csr_data[0];
            CSR_LIMIT_ENABLE: enable_in    = csr_data[0];
            default: ;
         endcase
      end
   end

   // Select the mass and form the widened thresholds
   always_comb begin
      word_mass     = use_gross_ff ? gross_mass : net_mass;
      lower_x       = {lower_ff[MASS_WIDTH-1], lower_ff};
      upper_x       = {upper_ff[MASS_WIDTH-1], upper_ff};
      hyst_x        = {2'b00, hyst_ff};
      mass_x        = {word_mass[MASS_WIDTH-1], word_mass};
      lower_plus_h  = lower_x + hyst_x;
      upper_minus_h = upper_x - hyst_x;
      span          = upper_x - lower_x;
      cfg_ok        = (lower_x <= upper_x) && (hyst_x <= span);
   end

   // Classify with hysteresis from the last stable class
   always_comb begin
      off       = calibrating | ~enable_ff;
      cls_valid = class_valid_ff & ~off;
      if (cls_valid && stable_class_ff == ST_LOW) begin
         priority if (mass_x > upper_x)       cls_result = ST_HIGH;
         else if (mass_x >= lower_plus_h)     cls_result = ST_OK;
         else                                 cls_result = ST_LOW;
      end else if (cls_valid && stable_class_ff == ST_HIGH) begin
         priority if (mass_x < lower_x)       cls_result = ST_LOW;
         else if (mass_x <= upper_minus_h)    cls_result = ST_OK;
         else                                 cls_result = ST_HIGH;
      end else begin
         priority if (mass_x < lower_x)       cls_result = ST_LOW;
         else if (mass_x > upper_x)           cls_result = ST_HIGH;
         else                                 cls_result = ST_OK;
      end
   end

   // Pick the state in priority order and advance the class state
   always_comb begin
      fault           = sample_invalid | ~cfg_ok;
      qualified       = 1'b0;
      ok_entry        = 1'b0;
      stable_class_in = off ? ST_DISABLED : stable_class_ff;
      class_valid_in  = cls_valid;
      priority if (fault) begin
         state_pick = ST_FAULT;
      end else if (overload_flag) begin
         state_pick = ST_OVERLOAD;
      end else if (off) begin
         state_pick = ST_DISABLED;
      end else if (!stable_flag) begin
         state_pick = cls_valid ? stable_class_ff : ST_DISABLED;
      end else begin
         state_pick      = cls_result;
         qualified       = 1'b1;
         ok_entry        = (cls_result == ST_OK) && !(cls_valid && stable_class_ff == ST_OK);
         stable_class_in = cls_result;
         class_valid_in  = 1'b1;
      end
      out_state_in = state_pick;
   end

   // Build the result word
   always_comb begin
      word_flags.state_code = state_pick;
      word_flags.changed    = (state_pick != out_state_ff);
      word_flags.qualified  = qualified;
      word_flags.ok_entry   = ok_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff        <= '0;
         upper_ff        <= '0;
         hyst_ff         <= '0;
         use_gross_ff    <= 1'b0;
         enable_ff       <= 1'b0;
         stable_class_ff <= ST_DISABLED;
         class_valid_ff  <= 1'b0;
         out_state_ff    <= ST_DISABLED;
      end else begin
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         hyst_ff      <= hyst_in;
         use_gross_ff <= use_gross_in;
         enable_ff    <= enable_in;
         if (item_accept) begin
            stable_class_ff <= stable_class_in;
            class_valid_ff  <= class_valid_in;
            out_state_ff    <= out_state_in;
         end
      end
   end

endmodule

// ===== rtl/cwlc_queue.sv =====
// Short result queue between the front end and the output stage.
`timescale 1ns / 1ps

module cwlc_queue #(
   parameter int WIDTH = cwlc_pkg::FLAGS_W + cwlc_pkg::MASS_WIDTH_DEF,
   parameter int DEPTH = cwlc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_word,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_word
);
   import cwlc_pkg::*;

   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]   entry_ff [DEPTH];
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign head_word = entry_ff[rd_ptr_ff];

   // Advance pointers and count; wrap at the last entry
   always_comb begin
      do_push   = push & ~full;
      do_pop    = pop & ~empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed word
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/cwlc_back.sv =====
// Back end: output register that presents the oldest result word.
`timescale 1ns / 1ps

module cwlc_back #(
   parameter int WIDTH = cwlc_pkg::FLAGS_W + cwlc_pkg::MASS_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  logic [WIDTH-1:0] q_word,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output logic [WIDTH-1:0] rsp_word
);
   import cwlc_pkg::*;

   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] word_ff, word_in;

   // Refill the output register when it is free or being taken
   always_comb begin
      q_pop    = ~q_empty & (~valid_ff | rsp_pop);
      valid_in = q_pop | (valid_ff & ~rsp_pop);
      word_in  = q_pop ? q_word : word_ff;
   end

   assign rsp_empty = ~valid_ff;
   assign rsp_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the word while the receiver stalls
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

// ===== rtl/checkweigh_limit_classifier.sv =====
// Top level of the checkweigh limit classifier.
`timescale 1ns / 1ps
//
// Usage:
//   Input words enter through req_push / req_full: a sample is taken at each
//   rising edge with req_push high and req_full low, one per cycle at most.
//   Results leave through rsp_empty / rsp_pop: the oldest result sits on the
//   rsp_ ports while rsp_empty is low and is taken on an edge with rsp_pop high.
//   Registers are written over csr_valid / csr_ready (always ready) with
//   csr_index selecting lower limit, upper limit, hysteresis, gross select
//   and limit enable; write them only while no result is outstanding.
//   Path: an accepted word goes through the queue into the output register.
//   Throughput: one word per cycle while req_full is low; classification and class
//   update are done in the cycle of acceptance, so there is no loop across samples.
//   Buffering: the front-to-back queue holds QUEUE_DEPTH words and the output
//   register one more; when the receiver stalls, req_full rises once all are
//   occupied and falls the cycle after a word is taken.
//   Reset (synchronous): clears registers to zero, class state to disabled,
//   and empties the queue and output register.

module checkweigh_limit_classifier #(
   parameter int MASS_WIDTH  = cwlc_pkg::MASS_WIDTH_DEF,
   parameter int QUEUE_DEPTH = cwlc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration port
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cwlc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [MASS_WIDTH-1:0]              csr_data,
   // Input channel
   input  logic                               req_push,
   output logic                               req_full,
   input  logic signed [MASS_WIDTH-1:0]       req_gross_mass,
   input  logic signed [MASS_WIDTH-1:0]       req_net_mass,
   input  logic                               req_stable_flag,
   input  logic                               req_overload_flag,
   input  logic                               req_sample_invalid,
   input  logic                               req_calibrating,
   // Result channel
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [cwlc_pkg::STATE_W-1:0]       rsp_state_code,
   output logic                               rsp_changed,
   output logic                               rsp_qualified,
   output logic                               rsp_ok_entry,
   output logic signed [MASS_WIDTH-1:0]       rsp_evaluated_mass
);
   import cwlc_pkg::*;

   localparam int WORD_W = FLAGS_W + MASS_WIDTH;

   logic                         item_accept;
   logic                         q_full, q_empty, q_pop;
   rsp_flags_type                front_flags, out_flags;
   logic signed [MASS_WIDTH-1:0] front_mass;
   logic [WORD_W-1:0]            q_push_word, q_head_word, out_word;

   assign csr_ready   = 1'b1;
   assign req_full    = q_full;
   assign item_accept = req_push & ~q_full;

   // Classify accepted samples
   cwlc_front #(
      .MASS_WIDTH (MASS_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .item_accept    (item_accept),
      .gross_mass     (req_gross_mass),
      .net_mass       (req_net_mass),
      .stable_flag    (req_stable_flag),
      .overload_flag  (req_overload_flag),
      .sample_invalid (req_sample_invalid),
      .calibrating    (req_calibrating),
      .word_flags     (front_flags),
      .word_mass      (front_mass)
   );

   assign q_push_word = {front_flags, front_mass};

   // Buffer result words between front and back
   cwlc_queue #(
      .WIDTH (WORD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_accept),
      .push_word (q_push_word),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_word (q_head_word)
   );

   // Present results to the receiver
   cwlc_back #(
      .WIDTH (WORD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_word    (q_head_word),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_word  (out_word)
   );

   // Unpack the output word
   assign out_flags          = out_word[WORD_W-1 -: FLAGS_W];
   assign rsp_evaluated_mass = out_word[MASS_WIDTH-1:0];
   assign rsp_state_code     = out_flags.state_code;
   assign rsp_changed        = out_flags.changed;
   assign rsp_qualified      = out_flags.qualified;
   assign rsp_ok_entry       = out_flags.ok_entry;

endmodule

// ===== rtl/cwlc_checker.sv =====
// Port-level checker of the checkweigh limit classifier, bound to the top level.
`timescale 1ns / 1ps
`include "checkweigh_limit_classifier_assert.svh"

module cwlc_checker #(
   parameter int MASS_WIDTH = cwlc_pkg::MASS_WIDTH_DEF
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_full,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input logic [cwlc_pkg::STATE_W-1:0]       rsp_state_code,
   input logic                               rsp_qualified,
   input logic                               rsp_ok_entry,
   input logic signed [MASS_WIDTH-1:0]       rsp_evaluated_mass
);
   import cwlc_pkg::*;

   // Reset leaves the block empty and ready for words
   `CWLC_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full)

   // A qualified word always carries a low, ok or high class
   `CWLC_ASSERT_IMPL(a_qualified_class, clock, reset, !rsp_empty && rsp_qualified, rsp_state_code == ST_LOW || rsp_state_code == ST_OK || rsp_state_code == ST_HIGH)

   // Ok entry only on a qualified ok word
   `CWLC_ASSERT_IMPL(a_ok_entry, clock, reset, !rsp_empty && rsp_ok_entry, rsp_qualified && rsp_state_code == ST_OK)

   // A stalled word stays put
   `CWLC_ASSERT_NEXT(a_stall_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_state_code) && $stable(rsp_evaluated_mass))

endmodule

bind checkweigh_limit_classifier cwlc_checker #(.MASS_WIDTH(MASS_WIDTH)) u_cwlc_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench of the checkweigh limit classifier.
`timescale 1ns / 1ps

module testbench;
   import cwlc_pkg::*;

   localparam int MASS_W = MASS_WIDTH_DEF;
   localparam longint MASS_MAX = (longint'(1) <<< (MASS_W - 1)) - 1;
   localparam longint MASS_MIN = -MASS_MAX - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_CAP = 40;

   typedef struct {
      logic signed [MASS_W-1:0] gross_mass;
      logic signed [MASS_W-1:0] net_mass;
      logic                     stable_flag;
      logic                     overload_flag;
      logic                     sample_invalid;
      logic                     calibrating;
   } sample_type;

   typedef struct {
      logic [STATE_W-1:0]       state_code;
      logic                     changed;
      logic                     qualified;
      logic                     ok_entry;
      logic signed [MASS_W-1:0] evaluated_mass;
   } verdict_type;

   typedef enum {POP_ALWAYS, POP_COIN, POP_HOLD, POP_MOSTLY} pop_mode_type;

   // Limit predictor plus the queue of verdicts still owed by the block
   class weigh_scoreboard;
      longint      lo_limit, hi_limit, band;
      bit          pick_gross, enabled;
      state_type   held_class, last_state;
      bit          held_valid;
      verdict_type verdict_q[$];
      int          error_count;

      function new();
         lo_limit = 0;
         hi_limit = 0;
         band = 0;
         pick_gross = 0;
         enabled = 0;
         held_class = ST_DISABLED;
         last_state = ST_DISABLED;
         held_valid = 0;
         error_count = 0;
      endfunction

      task report(string msg);
         if (error_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
         error_count++;
      endtask

      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [MASS_W-1:0] data);
         case (index)
            CSR_LOWER_LIMIT:  lo_limit = $signed(data);
            CSR_UPPER_LIMIT:  hi_limit = $signed(data);
            CSR_HYSTERESIS:   band = data[MASS_W-2:0];
            CSR_USE_GROSS:    pick_gross = data[0];
            CSR_LIMIT_ENABLE: enabled = data[0];
            default: ;
         endcase
      endfunction

      // Entering ok from low or high needs the band crossed; otherwise plain window
      function state_type classify(longint mass);
         if (held_valid && held_class == ST_LOW) begin
            if (mass > hi_limit) return ST_HIGH;
            if (mass >= lo_limit + band) return ST_OK;
            return ST_LOW;
         end
         if (held_valid && held_class == ST_HIGH) begin
            if (mass < lo_limit) return ST_LOW;
            if (mass <= hi_limit - band) return ST_OK;
            return ST_HIGH;
         end
         if (mass < lo_limit) return ST_LOW;
         if (mass > hi_limit) return ST_HIGH;
         return ST_OK;
      endfunction

      function void note_sample(sample_type s);
         verdict_type v;
         longint      mass;
         bit          cfg_valid;
         bit          off;
         state_type   next;
         mass = pick_gross ? s.gross_mass : s.net_mass;
         cfg_valid = lo_limit <= hi_limit && band <= hi_limit - lo_limit;
         off = s.calibrating || !enabled;
         v.qualified = 0;
         v.ok_entry = 0;
         // Drop the held class while calibrating or disabled
         if (off) begin
            held_class = ST_DISABLED;
            held_valid = 0;
         end
         if (s.sample_invalid || !cfg_valid) begin
            next = ST_FAULT;
         end else if (s.overload_flag) begin
            next = ST_OVERLOAD;
         end else if (off) begin
            next = ST_DISABLED;
         end else if (!s.stable_flag) begin
            if (held_valid) next = held_class;
            else next = ST_DISABLED;
         end else begin
            next = classify(mass);
            v.qualified = 1;
            v.ok_entry = next == ST_OK && !(held_valid && held_class == ST_OK);
            held_class = next;
            held_valid = 1;
         end
         v.state_code = next;
         v.changed = next != last_state;
         v.evaluated_mass = mass[MASS_W-1:0];
         last_state = next;
         verdict_q.push_back(v);
      endfunction

      task check_result(verdict_type got);
         verdict_type want;
         if (verdict_q.size() == 0) begin
            report($sformatf("result word with none expected, state %0d", got.state_code));
            return;
         end
         want = verdict_q.pop_front();
         if (got.state_code !== want.state_code)
            report($sformatf("state_code got %0d expected %0d",
                             got.state_code, want.state_code));
         if (got.changed !== want.changed)
            report($sformatf("changed got %0d expected %0d",
                             got.changed, want.changed));
         if (got.qualified !== want.qualified)
            report($sformatf("qualified got %0d expected %0d",
                             got.qualified, want.qualified));
         if (got.ok_entry !== want.ok_entry)
            report($sformatf("ok_entry got %0d expected %0d",
                             got.ok_entry, want.ok_entry));
         if (got.evaluated_mass !== want.evaluated_mass)
            report($sformatf("evaluated_mass got %0d expected %0d",
                             got.evaluated_mass, want.evaluated_mass));
      endtask

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index = '0;
   logic [MASS_W-1:0]           csr_data = '0;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic signed [MASS_W-1:0]    req_gross_mass = '0;
   logic signed [MASS_W-1:0]    req_net_mass = '0;
   logic                        req_stable_flag = 1'b0;
   logic                        req_overload_flag = 1'b0;
   logic                        req_sample_invalid = 1'b0;
   logic                        req_calibrating = 1'b0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic [STATE_W-1:0]          rsp_state_code;
   logic                        rsp_changed;
   logic                        rsp_qualified;
   logic                        rsp_ok_entry;
   logic signed [MASS_W-1:0]    rsp_evaluated_mass;

   weigh_scoreboard sb = new();
   int           cycle_count = 0;
   pop_mode_type pop_mode = POP_ALWAYS;
   int           mode_left = 0;

   checkweigh_limit_classifier uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Observe every handshake at the edge it completes on
   always @(posedge clock) begin : monitor
      sample_type  s;
      verdict_type r;
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_register(csr_index, csr_data);
         if (req_push && !req_full) begin
            s.gross_mass = req_gross_mass;
            s.net_mass = req_net_mass;
            s.stable_flag = req_stable_flag;
            s.overload_flag = req_overload_flag;
            s.sample_invalid = req_sample_invalid;
            s.calibrating = req_calibrating;
            sb.note_sample(s);
         end
         if (rsp_pop && !rsp_empty) begin
            r.state_code = rsp_state_code;
            r.changed = rsp_changed;
            r.qualified = rsp_qualified;
            r.ok_entry = rsp_ok_entry;
            r.evaluated_mass = rsp_evaluated_mass;
            sb.check_result(r);
         end
      end
   end

   // Receiver: switch between stretches of steady, patchy and stalled pops
   always @(posedge clock) begin
      if (mode_left == 0) begin
         pop_mode = pop_mode_type'($urandom_range(0, 3));
         mode_left = (pop_mode == POP_HOLD) ? $urandom_range(2, 25) : $urandom_range(10, 80);
      end else begin
         mode_left--;
      end
      case (pop_mode)
         POP_ALWAYS: rsp_pop <= 1'b1;
         POP_COIN:   rsp_pop <= 1'($urandom_range(0, 1));
         POP_HOLD:   rsp_pop <= 1'b0;
         default:    rsp_pop <= $urandom_range(0, 7) != 0;
      endcase
   end

   // Present one word and hold it until the block takes it
   task automatic drive_sample(input sample_type s);
      req_push <= 1'b1;
      req_gross_mass <= s.gross_mass;
      req_net_mass <= s.net_mass;
      req_stable_flag <= s.stable_flag;
      req_overload_flag <= s.overload_flag;
      req_sample_invalid <= s.sample_invalid;
      req_calibrating <= s.calibrating;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic drive_weight(input longint gross, input longint net,
                               input bit stable, input bit overload,
                               input bit invalid, input bit calib);
      sample_type s;
      s.gross_mass = gross[MASS_W-1:0];
      s.net_mass = net[MASS_W-1:0];
      s.stable_flag = stable;
      s.overload_flag = overload;
      s.sample_invalid = invalid;
      s.calibrating = calib;
      drive_sample(s);
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_push <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Leave csr_valid high so back-to-back writes need no drop
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [MASS_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_limits(input longint lower, input longint upper,
                              input longint hyst, input bit gross, input bit enable);
      write_reg(CSR_LOWER_LIMIT, lower[MASS_W-1:0]);
      write_reg(CSR_UPPER_LIMIT, upper[MASS_W-1:0]);
      // Bits above each register's width carry noise and must be ignored
      write_reg(CSR_HYSTERESIS, {1'($urandom_range(0, 1)), hyst[MASS_W-2:0]});
      write_reg(CSR_USE_GROSS, {(MASS_W-1)'($urandom()), gross});
      write_reg(CSR_LIMIT_ENABLE, {(MASS_W-1)'($urandom()), enable});
      csr_valid <= 1'b0;
   endtask

   task automatic load_random_limits();
      longint lower, upper, hyst, span;
      case ($urandom_range(0, 7))
         0: begin
            // Full range: the band arithmetic needs the extra bit
            lower = MASS_MIN;
            upper = MASS_MAX;
            hyst = longint'($urandom()) & MASS_MAX;
         end
         1: begin
            // Crossed limits or a band wider than the window
            lower = longint'($urandom_range(0, 1000)) - 500;
            span = $urandom_range(0, 1000);
            if ($urandom_range(0, 1)) begin
               upper = lower - 1 - span;
               hyst = 0;
            end else begin
               upper = lower + span;
               hyst = span + 1 + longint'($urandom_range(0, 3));
            end
         end
         2: begin
            lower = longint'($signed($urandom()));
            upper = lower;
            hyst = 0;
         end
         default: begin
            lower = longint'($signed($urandom())) >>> 2;
            span = $urandom_range(0, 5000);
            upper = lower + span;
            hyst = $urandom_range(0, 32'(span));
         end
      endcase
      load_limits(lower, upper, hyst, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
   endtask

   // Masses cluster on the limit and band edges, with some noise and extremes
   function automatic longint pick_mass();
      longint anchor, v;
      case ($urandom_range(0, 9))
         0, 1: return longint'($signed($urandom()));
         2: return $urandom_range(0, 1) ? MASS_MIN : MASS_MAX;
         default: begin
            case ($urandom_range(0, 3))
               0: anchor = sb.lo_limit;
               1: anchor = sb.hi_limit;
               2: anchor = sb.lo_limit + sb.band;
               default: anchor = sb.hi_limit - sb.band;
            endcase
            v = anchor + longint'($urandom_range(0, 6)) - 3;
            if (v < MASS_MIN || v > MASS_MAX) v = anchor;
            return v;
         end
      endcase
   endfunction

   task automatic drive_random_sample();
      sample_type s;
      s.gross_mass = MASS_W'(pick_mass());
      s.net_mass = MASS_W'(pick_mass());
      s.stable_flag = $urandom_range(0, 3) != 0;
      s.overload_flag = $urandom_range(0, 11) == 0;
      s.sample_invalid = $urandom_range(0, 15) == 0;
      s.calibrating = $urandom_range(0, 15) == 0;
      drive_sample(s);
   endtask

   // Wait out every owed word, then let the pipeline settle
   task automatic drain();
      req_push <= 1'b0;
      // Let the monitor note the last accepted word before the count is read
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int burst_left;
      int gap;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: limits off, overload still wins
      drive_weight(0, 0, 1, 0, 0, 0);
      drive_weight(0, 0, 1, 1, 0, 0);
      drain();

      // Unmapped indexes must leave every register alone
      for (int idx = int'(CSR_LIMIT_ENABLE) + 1; idx < 2 ** CSR_INDEX_W; idx++)
         write_reg(CSR_INDEX_W'(idx), MASS_W'($urandom()));
      load_limits(-1000, 1000, 100, 1, 1);
      drive_weight(-1001, 0, 1, 0, 0, 0);
      drive_weight(-1000, 1, 1, 0, 0, 0);
      drive_weight(500, 2, 0, 0, 0, 0);
      drive_weight(-900, 3, 1, 0, 0, 0);
      drive_weight(1000, 4, 1, 0, 0, 0);
      drive_weight(1001, 5, 1, 0, 0, 0);
      drive_weight(901, 6, 1, 0, 0, 0);
      drive_weight(900, 7, 1, 0, 0, 0);
      drive_weight(2000, 8, 1, 0, 0, 0);
      drive_weight(-1001, 9, 1, 0, 0, 0);
      drive_weight(1001, 10, 1, 0, 0, 0);
      // Fault over overload, class kept through both
      drive_weight(0, 11, 1, 1, 1, 0);
      drive_weight(0, 12, 1, 1, 0, 0);
      drive_weight(0, 13, 0, 0, 0, 0);
      // Calibration clears the class
      drive_weight(0, 14, 1, 0, 0, 1);
      drive_weight(0, 15, 0, 0, 0, 0);
      drive_weight(MASS_MAX, MASS_MIN, 1, 0, 0, 0);
      drive_weight(MASS_MIN, MASS_MAX, 1, 0, 0, 0);
      drain();

      // Crossed limits, then a band wider than the window
      load_limits(5, -5, 0, 0, 1);
      drive_weight(0, 7, 1, 0, 0, 0);
      drain();
      load_limits(0, 10, 11, 0, 1);
      drive_weight(3, 5, 1, 0, 0, 0);
      drain();

      // Widest window with the widest band
      load_limits(MASS_MIN, MASS_MAX, MASS_MAX, 0, 1);
      drive_weight(MASS_MAX, MASS_MIN, 1, 0, 0, 0);
      drive_weight(MASS_MIN, MASS_MAX, 1, 0, 0, 0);
      drain();

      // Random phases: bursts of words with gaps, new limits per phase
      burst_left = 0;
      for (int phase = 0; phase < 8; phase++) begin
         load_random_limits();
         for (int n = 0; n < 50; n++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               pause(gap);
            end
            burst_left--;
            drive_random_sample();
         end
         drain();
      end

      // Catch any stray word after the last one owed
      repeat (10) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cwlc_pkg.sv
rtl/cwlc_front.sv
rtl/cwlc_queue.sv
rtl/cwlc_back.sv
rtl/checkweigh_limit_classifier.sv
rtl/cwlc_checker.sv
tb/testbench.sv
